// File: rtl/kltc_pkg.sv
`timescale 1ns / 1ps
// Shared types, token codes and the reserved-word table for the keyword lexer.
// No dependencies; every other file refers to this package by scoped names.
package kltc_pkg;

	localparam int WORD_BUF_DEPTH  = 8;
	localparam int KW_MAX_LEN      = 7;
	localparam int KW_COUNT        = 15;
	localparam int OUT_QUEUE_DEPTH = 4;

	typedef enum logic [5:0] {
		TK_BEGIN     = 6'd0,
		TK_END       = 6'd1,
		TK_PROC      = 6'd2,
		TK_EQUAL     = 6'd3,
		TK_LEFTPAR   = 6'd4,
		TK_RIGHTPAR  = 6'd5,
		TK_INTEGER   = 6'd6,
		TK_BOOLEAN   = 6'd7,
		TK_COMMA     = 6'd8,
		TK_SEMICOLON = 6'd9,
		TK_ASSIGN    = 6'd10,
		TK_READ      = 6'd11,
		TK_WRITE     = 6'd12,
		TK_IF        = 6'd13,
		TK_THEN      = 6'd14,
		TK_ELSE      = 6'd15,
		TK_WHILE     = 6'd16,
		TK_DO        = 6'd17,
		TK_CALL      = 6'd18,
		TK_OR        = 6'd19,
		TK_AND       = 6'd20,
		TK_NOT       = 6'd21,
		TK_MINUS     = 6'd22,
		TK_ID        = 6'd23,
		TK_LT        = 6'd24,
		TK_GT        = 6'd25,
		TK_GE        = 6'd26,
		TK_LE        = 6'd27,
		TK_NE        = 6'd28,
		TK_PLUS      = 6'd29,
		TK_STAR      = 6'd30,
		TK_DIV       = 6'd31,
		TK_NUMERAL   = 6'd32,
		TK_DOLLAR    = 6'd33,
		TK_ERROR     = 6'd34,
		TK_EOF       = 6'd35
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		tok_kind_t  token_kind;
		logic [7:0] token_length;
		logic       last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [1:0] count;
		out_word_t  first;
		out_word_t  second;
	} push_t;

	typedef struct packed {
		logic [8*KW_MAX_LEN-1:0] text;
		logic [2:0]              len;
		tok_kind_t               kind;
	} kw_entry_t;

	// Text is right-aligned: the first letter sits in the highest used byte.
	localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
		'{56'("proc"),    3'd4, TK_PROC},
		'{56'("call"),    3'd4, TK_CALL},
		'{56'("begin"),   3'd5, TK_BEGIN},
		'{56'("end"),     3'd3, TK_END},
		'{56'("integer"), 3'd7, TK_INTEGER},
		'{56'("boolean"), 3'd7, TK_BOOLEAN},
		'{56'("read"),    3'd4, TK_READ},
		'{56'("write"),   3'd5, TK_WRITE},
		'{56'("if"),      3'd2, TK_IF},
		'{56'("then"),    3'd4, TK_THEN},
		'{56'("else"),    3'd4, TK_ELSE},
		'{56'("while"),   3'd5, TK_WHILE},
		'{56'("do"),      3'd2, TK_DO},
		'{56'("and"),     3'd3, TK_AND},
		'{56'("or"),      3'd2, TK_OR}
	};

	function automatic tok_kind_t classify_word(input logic [KW_MAX_LEN-1:0][7:0] w,
			input logic [7:0] count);
		tok_kind_t kind;
		logic      same;
		kind = TK_ID;
		for (int i = 0; i < KW_COUNT; i++) begin
			same = (count == 8'(KW_TABLE[i].len));
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (j < int'(KW_TABLE[i].len)) begin
					if (w[j] != KW_TABLE[i].text[8*(int'(KW_TABLE[i].len) - 1 - j) +: 8]) begin
						same = 1'b0;
					end
				end
			end
			if (same) begin
				kind = KW_TABLE[i].kind;
			end
		end
		return kind;
	endfunction

endpackage

// File: rtl/keyword_lexer_token_classifier.sv
`timescale 1ns / 1ps
// Keyword lexer: one source byte per word in, tokens (kind, length) out.
// The token a byte completes is written into the result queue as that byte is taken.
// Throughput: one byte per cycle; a byte that yields two tokens pushes both at once,
// and in_ready drops while the four-entry result queue has fewer than two free slots.
// Reset: scanner idle between tokens, length count zero, result queue empty; the word
// buffer is not reset. Depends on kltc_pkg, kltc_scan and kltc_out_queue.
module keyword_lexer_token_classifier #(
	parameter int WORD_BUFFER_DEPTH = kltc_pkg::WORD_BUF_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kltc_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output kltc_pkg::out_word_t out_word
);

	kltc_pkg::push_t push;
	logic            has_room;
	logic            fire;

	assign in_ready = has_room;
	assign fire     = in_valid && in_ready;

	kltc_scan #(
		.WORD_BUFFER_DEPTH(WORD_BUFFER_DEPTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_word (in_word),
		.push    (push)
	);

	kltc_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// File: rtl/kltc_scan.sv
`timescale 1ns / 1ps
// Scanner core: mode, length count and word buffer, with the logic that turns one byte
// into up to two tokens. Depends on kltc_pkg.
module kltc_scan #(
	parameter int WORD_BUFFER_DEPTH = kltc_pkg::WORD_BUF_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kltc_pkg::in_word_t in_word,
	output kltc_pkg::push_t   push
);

	localparam int IDX_W = $clog2(WORD_BUFFER_DEPTH);

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ID,
		MODE_NUM,
		MODE_COLON,
		MODE_LT,
		MODE_GT
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic                load;
		logic                emit;
		kltc_pkg::tok_kind_t kind;
	} start_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic start_t start_byte(input logic [7:0] c);
		start_t s;
		s.mode = MODE_IDLE;
		s.load = 1'b0;
		s.emit = 1'b0;
		s.kind = kltc_pkg::TK_ERROR;
		priority if (is_space(c)) begin
		end else if (c == CH_COLON) begin
			s.mode = MODE_COLON;
		end else if (c == CH_LT) begin
			s.mode = MODE_LT;
		end else if (c == CH_GT) begin
			s.mode = MODE_GT;
		end else if (is_digit(c)) begin
			s.mode = MODE_NUM;
			s.load = 1'b1;
		end else if (is_alpha(c)) begin
			s.mode = MODE_ID;
			s.load = 1'b1;
		end else begin
			s.emit = 1'b1;
			unique case (c)
				CH_SEMI:   s.kind = kltc_pkg::TK_SEMICOLON;
				CH_COMMA:  s.kind = kltc_pkg::TK_COMMA;
				CH_LPAR:   s.kind = kltc_pkg::TK_LEFTPAR;
				CH_RPAR:   s.kind = kltc_pkg::TK_RIGHTPAR;
				CH_MINUS:  s.kind = kltc_pkg::TK_MINUS;
				CH_EQ:     s.kind = kltc_pkg::TK_EQUAL;
				CH_PLUS:   s.kind = kltc_pkg::TK_PLUS;
				CH_STAR:   s.kind = kltc_pkg::TK_STAR;
				CH_SLASH:  s.kind = kltc_pkg::TK_DIV;
				CH_DOLLAR: s.kind = kltc_pkg::TK_DOLLAR;
				default:   s.kind = kltc_pkg::TK_ERROR;
			endcase
		end
		return s;
	endfunction

	mode_t                                   mode_q, mode_d;
	logic [7:0]                              count_q, count_d, count_inc;
	logic [7:0]                              word_q [WORD_BUFFER_DEPTH];
	logic [kltc_pkg::KW_MAX_LEN-1:0][7:0]    word_view;
	logic                                    buf_we;
	logic [IDX_W-1:0]                        buf_idx;
	logic [7:0]                              c;
	logic                                    eoi;
	start_t                                  st;
	logic                                    use_start;
	kltc_pkg::tok_kind_t                     word_kind;
	logic                                    a_v, b_v;
	kltc_pkg::tok_kind_t                     a_kind, b_kind;
	logic [7:0]                              a_len, b_len;
	kltc_pkg::out_word_t                     a_word, b_word;

	assign c   = in_word.char_in;
	assign eoi = in_word.end_of_input;

	always_comb begin
		for (int j = 0; j < kltc_pkg::KW_MAX_LEN; j++) begin
			word_view[j] = word_q[j];
		end
	end

	assign word_kind = kltc_pkg::classify_word(word_view, count_q);
	assign st        = start_byte(c);
	assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;

	always_comb begin
		mode_d    = mode_q;
		count_d   = count_q;
		buf_we    = 1'b0;
		buf_idx   = '0;
		use_start = 1'b0;
		a_v       = 1'b0;
		a_kind    = kltc_pkg::TK_ERROR;
		a_len     = 8'd0;
		b_v       = 1'b0;
		b_kind    = kltc_pkg::TK_ERROR;
		b_len     = 8'd0;
		if (eoi) begin
			unique case (mode_q)
				MODE_ID: begin
					a_v    = 1'b1;
					a_kind = word_kind;
					a_len  = count_q;
				end
				MODE_NUM: begin
					a_v    = 1'b1;
					a_kind = kltc_pkg::TK_NUMERAL;
					a_len  = count_q;
				end
				MODE_COLON: begin
					a_v    = 1'b1;
					a_kind = kltc_pkg::TK_ERROR;
					a_len  = 8'd1;
				end
				MODE_LT: begin
					a_v    = 1'b1;
					a_kind = kltc_pkg::TK_LT;
					a_len  = 8'd1;
				end
				MODE_GT: begin
					a_v    = 1'b1;
					a_kind = kltc_pkg::TK_GT;
					a_len  = 8'd1;
				end
				default: begin
				end
			endcase
			b_v     = 1'b1;
			b_kind  = kltc_pkg::TK_EOF;
			b_len   = 8'd0;
			mode_d  = MODE_IDLE;
			count_d = 8'd0;
		end else begin
			unique case (mode_q)
				MODE_ID: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (count_q < 8'(WORD_BUFFER_DEPTH)) begin
							buf_we  = 1'b1;
							buf_idx = count_q[IDX_W-1:0];
						end
						count_d = count_inc;
					end else begin
						a_v       = 1'b1;
						a_kind    = word_kind;
						a_len     = count_q;
						use_start = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(c)) begin
						count_d = count_inc;
					end else begin
						a_v       = 1'b1;
						a_kind    = kltc_pkg::TK_NUMERAL;
						a_len     = count_q;
						use_start = 1'b1;
					end
				end
				MODE_COLON: begin
					mode_d = MODE_IDLE;
					a_v    = 1'b1;
					a_len  = 8'd2;
					a_kind = (c == CH_EQ) ? kltc_pkg::TK_ASSIGN : kltc_pkg::TK_ERROR;
				end
				MODE_LT: begin
					mode_d = MODE_IDLE;
					a_v    = 1'b1;
					priority if (c == CH_EQ) begin
						a_kind = kltc_pkg::TK_LE;
						a_len  = 8'd2;
					end else if (c == CH_GT) begin
						a_kind = kltc_pkg::TK_NE;
						a_len  = 8'd2;
					end else begin
						a_kind    = kltc_pkg::TK_LT;
						a_len     = 8'd1;
						use_start = !is_space(c);
					end
				end
				MODE_GT: begin
					mode_d = MODE_IDLE;
					a_v    = 1'b1;
					if (c == CH_EQ) begin
						a_kind = kltc_pkg::TK_GE;
						a_len  = 8'd2;
					end else begin
						a_kind    = kltc_pkg::TK_GT;
						a_len     = 8'd1;
						use_start = !is_space(c);
					end
				end
				default: begin
					use_start = 1'b1;
				end
			endcase
			if (use_start) begin
				mode_d = st.mode;
				if (st.load) begin
					count_d = 8'd1;
				end
				if (st.mode == MODE_ID) begin
					buf_we  = 1'b1;
					buf_idx = '0;
				end
				b_v    = st.emit;
				b_kind = st.kind;
				b_len  = 8'd1;
			end
		end
	end

	always_comb begin
		a_word.token_kind   = a_kind;
		a_word.token_length = a_len;
		a_word.last_of_run  = !b_v;
		b_word.token_kind   = b_kind;
		b_word.token_length = b_len;
		b_word.last_of_run  = 1'b1;
		push.count          = fire ? (2'(a_v) + 2'(b_v)) : 2'd0;
		push.first          = a_v ? a_word : b_word;
		push.second         = b_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= 8'd0;
		end else if (fire) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && buf_we) begin
			word_q[buf_idx] <= c;
		end
	end

endmodule

// File: rtl/kltc_out_queue.sv
`timescale 1ns / 1ps
// Result queue taking up to two tokens a cycle and handing out one a cycle while out_ready is high.
// Depends on kltc_pkg.
module kltc_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  kltc_pkg::push_t     push,
	output logic                has_room,
	output logic                out_valid,
	input  logic                out_ready,
	output kltc_pkg::out_word_t out_word
);

	localparam int DEPTH = kltc_pkg::OUT_QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	kltc_pkg::out_word_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    fill_q;
	logic                pop;

	assign out_valid = fill_q != '0;
	assign pop       = out_valid && out_ready;
	assign has_room  = fill_q <= CNT_W'(DEPTH - 2);
	assign out_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			fill_q   <= fill_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.second;
		end
	end

endmodule
